// ===== rtl/core/lcfr_pkg.sv =====
// Shared types and constants for the length/checksum frame receiver.
// No dependencies.
`default_nettype none

package lcfr_pkg;

  localparam int OFFSET_BITS = 16;

  typedef enum logic [1:0] {
    KIND_STORE = 2'd0,
    KIND_ACK   = 2'd1,
    KIND_FAIL  = 2'd2,
    KIND_DONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    FAIL_NONE   = 2'd0,
    FAIL_CHECK  = 2'd1,
    FAIL_LENGTH = 2'd2
  } fail_code_t;

  localparam logic [7:0] REPLY_ACK = 8'h00;
  localparam logic [7:0] REPLY_ERR = 8'hFF;

endpackage

`default_nettype wire

// ===== rtl/core/lcfr_rx_if.sv =====
// Received byte channel: valid/ready handshake with byte and line-error flag.
// No dependencies.
`default_nettype none

interface lcfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       rx_error;

  modport source (output valid, output rx_byte, output rx_error, input ready);
  modport sink   (input valid, input rx_byte, input rx_error, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lcfr_res_if.sv =====
// Result channel: valid/ready handshake carrying one store, ack or end item.
// Depends on lcfr_pkg.
`default_nettype none

interface lcfr_res_if
  import lcfr_pkg::*;
;
  logic        valid;
  logic        ready;
  kind_t       kind;
  logic [15:0] write_address;
  logic [7:0]  data_byte;
  logic [7:0]  reply_byte;
  fail_code_t  fail_code;
  logic [15:0] total_count;

  modport source (output valid, output kind, output write_address, output data_byte,
                  output reply_byte, output fail_code, output total_count, input ready);
  modport sink   (input valid, input kind, input write_address, input data_byte,
                  input reply_byte, input fail_code, input total_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/length_checksum_frame_receiver.sv =====
// Top level of the length-prefixed chunk receiver with additive checksum.
// Depends on lcfr_pkg, lcfr_rx_if and lcfr_res_if.
//
// Usage:
//   in_rx   : received serial bytes, each with a line-error flag. Flagged
//             items are swallowed and leave every register untouched.
//   out_res : at most one result item per accepted byte: a payload store at
//             the running offset, a chunk ack, a transfer failure (reply FF)
//             or transfer completion (reply 00, total count).
//   cfg_we / cfg_wdata : writes expected_length, the payload budget of a
//             transfer; it is checked against each length byte.
// Output: a result is registered on out_res in the cycle after its byte is accepted.
// Throughput: one item per cycle while out_res is not stalling (see below); the chunk
// state update and result build are a single add/compare stage feeding the output register.
// Stall: in_rx.ready follows "output register empty or being taken", so a
// held result stalls the input only while out_res.ready is low; items that
// give no result still need that slot free.
// Reset (rst_n low, synchronous): no result pending, receiver awaits a length
// byte at offset zero, expected_length is zero.
`default_nettype none

module length_checksum_frame_receiver
  import lcfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  lcfr_rx_if.sink          in_rx,
  lcfr_res_if.source       out_res,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  // Config register
  logic [15:0] expected_length_r;

  // Chunk state
  logic                   in_payload_r,   in_payload_nxt;
  logic [7:0]             chunk_length_r, chunk_length_nxt;
  logic [7:0]             running_sum_r,  running_sum_nxt;
  logic [7:0]             chunk_index_r,  chunk_index_nxt;
  logic [OFFSET_BITS-1:0] offset_r,       offset_nxt;

  // Result being built this cycle
  logic        res_valid;
  kind_t       res_kind;
  logic [15:0] res_addr;
  logic [7:0]  res_data;
  logic [7:0]  res_reply;
  fail_code_t  res_code;
  logic [15:0] res_total;

  // Output register
  logic        out_valid_r;
  kind_t       out_kind_r;
  logic [15:0] out_addr_r;
  logic [7:0]  out_data_r;
  logic [7:0]  out_reply_r;
  fail_code_t  out_code_r;
  logic [15:0] out_total_r;

  logic accept;
  logic take;
  logic [OFFSET_BITS:0] need;      // offset plus payload bytes the new chunk asks for
  logic [8:0]           idx_inc;   // chunk_index + 1, room for 256
  logic [7:0]           sum_b;
  logic [OFFSET_BITS-1:0] addr_full;

  assign in_rx.ready = !out_valid_r || out_res.ready;
  assign accept      = in_rx.valid && in_rx.ready;
  assign take        = accept && !in_rx.rx_error;

  assign need      = {1'b0, offset_r} + {{(OFFSET_BITS-7){1'b0}}, in_rx.rx_byte - 8'd1};
  assign idx_inc   = {1'b0, chunk_index_r} + 9'd1;
  assign sum_b     = running_sum_r + in_rx.rx_byte;
  assign addr_full = offset_r + {{(OFFSET_BITS-8){1'b0}}, chunk_index_r};

  always_comb begin
    in_payload_nxt   = in_payload_r;
    chunk_length_nxt = chunk_length_r;
    running_sum_nxt  = running_sum_r;
    chunk_index_nxt  = chunk_index_r;
    offset_nxt       = offset_r;
    res_valid        = 1'b0;
    res_kind         = KIND_STORE;
    res_addr         = '0;
    res_data         = '0;
    res_reply        = REPLY_ACK;
    res_code         = FAIL_NONE;
    res_total        = offset_r[15:0];

    if (!in_payload_r) begin
      // length byte
      if (in_rx.rx_byte == 8'd0 ||
          need > {{(OFFSET_BITS-15){1'b0}}, expected_length_r}) begin
        res_valid        = 1'b1;
        res_kind         = KIND_FAIL;
        res_reply        = REPLY_ERR;
        res_code         = FAIL_LENGTH;
        offset_nxt       = '0;
        chunk_length_nxt = '0;
        running_sum_nxt  = '0;
        chunk_index_nxt  = '0;
      end else begin
        in_payload_nxt   = 1'b1;
        chunk_length_nxt = in_rx.rx_byte;
        running_sum_nxt  = in_rx.rx_byte;
        chunk_index_nxt  = '0;
      end
    end else if (idx_inc == {1'b0, chunk_length_r}) begin
      // check byte
      res_valid        = 1'b1;
      in_payload_nxt   = 1'b0;
      chunk_length_nxt = '0;
      running_sum_nxt  = '0;
      chunk_index_nxt  = '0;
      if (sum_b != 8'd0) begin
        res_kind   = KIND_FAIL;
        res_reply  = REPLY_ERR;
        res_code   = FAIL_CHECK;
        offset_nxt = '0;
      end else if (chunk_index_r == 8'd0) begin
        res_kind   = KIND_DONE;
        offset_nxt = '0;
      end else begin
        res_kind   = KIND_ACK;
        offset_nxt = addr_full;
        res_total  = addr_full[15:0];
      end
    end else begin
      // payload byte
      res_valid       = 1'b1;
      res_kind        = KIND_STORE;
      res_addr        = addr_full[15:0];
      res_data        = in_rx.rx_byte;
      running_sum_nxt = sum_b;
      chunk_index_nxt = idx_inc[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_length_r <= '0;
    end else if (cfg_we) begin
      expected_length_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_payload_r   <= 1'b0;
      chunk_length_r <= '0;
      running_sum_r  <= '0;
      chunk_index_r  <= '0;
      offset_r       <= '0;
    end else if (take) begin
      in_payload_r   <= in_payload_nxt;
      chunk_length_r <= chunk_length_nxt;
      running_sum_r  <= running_sum_nxt;
      chunk_index_r  <= chunk_index_nxt;
      offset_r       <= offset_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_rx.ready) begin
      out_valid_r <= take && res_valid;
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      out_kind_r  <= res_kind;
      out_addr_r  <= res_addr;
      out_data_r  <= res_data;
      out_reply_r <= res_reply;
      out_code_r  <= res_code;
      out_total_r <= res_total;
    end
  end

  assign out_res.valid         = out_valid_r;
  assign out_res.kind          = out_kind_r;
  assign out_res.write_address = out_addr_r;
  assign out_res.data_byte     = out_data_r;
  assign out_res.reply_byte    = out_reply_r;
  assign out_res.fail_code     = out_code_r;
  assign out_res.total_count   = out_total_r;

  // A transfer end always restarts at offset zero, awaiting a length byte
  a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    take && res_valid && (res_kind == KIND_FAIL || res_kind == KIND_DONE)
    |=> offset_r == '0 && !in_payload_r)
    else $error("transfer end did not restart the receiver");

  // Line-error items leave the chunk state alone
  a_error_byte_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_rx.rx_error
    |=> $stable(offset_r) && $stable(running_sum_r) && $stable(chunk_index_r)
        && $stable(in_payload_r))
    else $error("flagged byte changed chunk state");

  // Inside a chunk the payload count never reaches the length byte
  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_payload_r |-> chunk_index_r < chunk_length_r)
    else $error("chunk index out of range");

  // A result is registered only when an unflagged item was accepted
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(take))
    else $error("result without an accepted byte");

endmodule

`default_nettype wire
